FILE: design/tdcwd_pkg.sv
// Shared types and constants for the TDC word decoder with hit store.
// No dependencies; imported by the decoder and the core.
`timescale 1ns / 1ps

package tdcwd_pkg;

	// input modes
	localparam logic [1:0] MODE_READOUT  = 2'd0;
	localparam logic [1:0] MODE_READBACK = 2'd1;
	localparam logic [1:0] MODE_CLEAR    = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_DATA     = 2'd0;
	localparam logic [1:0] KIND_END      = 2'd1;
	localparam logic [1:0] KIND_READBACK = 2'd2;

	// configuration register indexes
	localparam int CFG_IDX_W = 4;
	localparam logic [CFG_IDX_W-1:0] REG_HEADER_VALUE    = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEADER_MASK     = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_RESOLUTION = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNELS_PER_MOD = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SLOT_FIRST_A    = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SLOT_SECOND_A   = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SLOT_FIRST_B    = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SLOT_SECOND_B   = 4'd7;

	// special words and slots
	localparam logic [31:0] WORD_ALL_ONES = 32'hffff_ffff;
	localparam logic [31:0] WORD_FILLER   = 32'hf1da_ffff;
	localparam logic [4:0]  SLOT_NO_STATUS = 5'd30;
	localparam logic [7:0]  COUNT_SAT     = 8'hff;
	localparam logic [15:0] WORDS_SAT     = 16'hffff;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] word;
		logic        first_word;
		logic [6:0]  query_channel;
		logic [5:0]  query_hit;
	} item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [5:0]  channel;
		logic [15:0] value;
		logic        module_index;
		logic [4:0]  slot_number;
		logic        slot_known;
		logic        hit_fifo_overflow;
		logic        output_fifo_overflow;
		logic        lock_failure;
		logic        hit_dropped;
		logic [15:0] words_seen;
		logic [7:0]  hit_count;
	} result_t;

	// decoder configuration view
	typedef struct packed {
		logic [31:0] header_value;
		logic [31:0] header_mask;
		logic        high_resolution;
		logic [4:0]  slot_first_a;
		logic [4:0]  slot_second_a;
		logic [4:0]  slot_first_b;
		logic [4:0]  slot_second_b;
	} dec_cfg_t;

	// decoded fields of one readout word
	typedef struct packed {
		logic        in_buffer;
		logic        is_data;
		logic [5:0]  chan;
		logic [4:0]  slot;
		logic        module_sel;
		logic        known;
		logic        hfo;
		logic        ofo;
		logic        lockf;
		logic        store;
		logic [15:0] raw;
	} dec_t;

endpackage

FILE: design/tdcwd_decode.sv
// Combinational field decode of one TDC readout word.
// Depends on tdcwd_pkg (dec_cfg_t, dec_t, special word constants).
`timescale 1ns / 1ps

module tdcwd_decode
	import tdcwd_pkg::*;
(
	input  logic [31:0] word,
	input  dec_cfg_t    cfg,
	output dec_t        dec
);

	logic [5:0] raw_chan;
	logic       status_ok;

	assign raw_chan = word[21:16];

	always_comb begin
		dec = '0;
		dec.in_buffer = (word != WORD_ALL_ONES) &&
			((word & cfg.header_mask) == cfg.header_value);
		dec.is_data = word[23];
		// high resolution merges pairs; otherwise odd channels move up by 16
		if (cfg.high_resolution) begin
			dec.chan = {1'b0, raw_chan[5:1]};
		end else begin
			dec.chan = {raw_chan[5], raw_chan[0], raw_chan[4:1]};
		end
		dec.slot = word[31:27];
		if (dec.slot == cfg.slot_first_a || dec.slot == cfg.slot_second_a) begin
			dec.known = 1'b1;
			dec.module_sel = 1'b0;
		end else if (dec.slot == cfg.slot_first_b || dec.slot == cfg.slot_second_b) begin
			dec.known = 1'b1;
			dec.module_sel = 1'b1;
		end else begin
			dec.known = 1'b0;
			dec.module_sel = 1'b0;
		end
		status_ok = dec.known && (dec.slot != SLOT_NO_STATUS);
		dec.hfo   = status_ok & word[24];
		dec.ofo   = status_ok & word[25];
		dec.lockf = status_ok & ~word[26];
		dec.store = status_ok && (word != WORD_FILLER);
		dec.raw   = word[15:0];
	end

endmodule

FILE: design/tdc_word_decoder_hit_store_core.sv
// Top level of the TDC readout word decoder with per-channel hit store.
// Depends on tdcwd_pkg and tdcwd_decode.
`timescale 1ns / 1ps

// Decodes 32-bit TDC readout words one transaction at a time. A word belongs
// to the current buffer while it is not all ones and matches header_value
// under header_mask; the first failing word reports end of buffer and later
// words are ignored until one arrives with first_word set. Header/trailer
// words (bit 23 clear) give no result. Data words give channel, time, slot
// mapping and status flags, and their time is appended to a per-channel hit
// table (count RAM of NUM_MODULES*NUM_CHANNELS bytes, time RAM of that many
// times MAX_HITS entries, both synchronous RAMs with registered read). Read-back mode
// returns a stored hit and the channel count; clear mode zeroes all counts at
// once through per-entry valid bits, so no clearing pass follows reset.
// Path from acceptance: clear and unused modes stay idle; words without a
// result go decode, idle; words that skip the table go decode, hand-off;
// stored hits go decode (count read), count (count/time write), hand-off;
// read-backs go decode (count read), count, time (if the hit is stored),
// hand-off (decode, hand-off for a query past the table). Leaving hand-off
// loads the result; a full, stalled output register holds the sequencer in
// hand-off as long as the stall lasts. One transaction is in work at a time;
// item_stall stays high until its result is in the output register, and that
// register holds a result while the next item is worked.
module tdc_word_decoder_hit_store_core
	import tdcwd_pkg::*;
#(
	parameter int NUM_CHANNELS = 64,
	parameter int MAX_HITS     = 20,
	parameter int NUM_MODULES  = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  item_t                item_data,
	output logic                 result_valid,
	input  logic                 result_stall,
	output result_t              result_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	localparam int TABLE_CH = NUM_MODULES * NUM_CHANNELS;
	localparam int TIDX_W   = $clog2(TABLE_CH);
	localparam int TIMES    = TABLE_CH * MAX_HITS;
	localparam int TADDR_W  = $clog2(TIMES);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DEC  = 3'd1;
	localparam logic [2:0] ST_CNT  = 3'd2;
	localparam logic [2:0] ST_TIM  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	// configuration
	logic [31:0] header_value_q;
	logic [31:0] header_mask_q;
	logic        high_res_q;
	logic [6:0]  cpm_q;
	logic [4:0]  slot_first_a_q;
	logic [4:0]  slot_second_a_q;
	logic [4:0]  slot_first_b_q;
	logic [4:0]  slot_second_b_q;

	// control
	logic [2:0]  state_q;
	logic        stopped_q;
	logic [15:0] words_q;
	item_t       item_q;
	result_t     res_q;
	result_t     out_q;
	logic        out_valid_q;
	logic [TABLE_CH-1:0] cnt_vld_q;

	// table access
	logic [TIDX_W-1:0]  tab_addr_q;
	logic               cnt_vld_rd_q;
	logic [7:0]         cnt_rdata_q;
	logic [15:0]        tim_rdata_q;
	logic [7:0]         cnt_mem [TABLE_CH];
	logic [15:0]        tim_mem [TIMES];

	dec_cfg_t           dcfg;
	dec_t               dec;
	logic               item_acc;
	logic               first;
	logic               stopped_eff;
	logic [15:0]        words_eff;
	logic [15:0]        words_inc;
	logic [7:0]         data_idx;
	logic               data_oob;
	logic               query_oob;
	logic [TIDX_W-1:0]  cnt_raddr;
	logic [7:0]         cnt_cur;
	logic [7:0]         cnt_next;
	logic               cnt_we;
	logic               tim_we;
	logic               tim_re;
	logic               rb_hit;
	logic [TADDR_W-1:0] tim_base;
	logic [TADDR_W-1:0] tim_addr;
	logic               out_free;

	assign cfg_ready    = 1'b1;
	assign item_stall   = (state_q != ST_IDLE);
	assign item_acc     = item_valid && !item_stall;
	assign result_valid = out_valid_q;
	assign result_data  = out_q;
	assign out_free     = !out_valid_q || !result_stall;

	// configuration writes; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_value_q  <= '0;
			header_mask_q   <= '0;
			high_res_q      <= 1'b1;
			cpm_q           <= 7'd32;
			slot_first_a_q  <= 5'd8;
			slot_second_a_q <= 5'd14;
			slot_first_b_q  <= 5'd10;
			slot_second_b_q <= 5'd16;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_HEADER_VALUE:     header_value_q  <= cfg_data;
				REG_HEADER_MASK:      header_mask_q   <= cfg_data;
				REG_HIGH_RESOLUTION:  high_res_q      <= cfg_data[0];
				REG_CHANNELS_PER_MOD: cpm_q           <= cfg_data[6:0];
				REG_SLOT_FIRST_A:     slot_first_a_q  <= cfg_data[4:0];
				REG_SLOT_SECOND_A:    slot_second_a_q <= cfg_data[4:0];
				REG_SLOT_FIRST_B:     slot_first_b_q  <= cfg_data[4:0];
				REG_SLOT_SECOND_B:    slot_second_b_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		dcfg.header_value    = header_value_q;
		dcfg.header_mask     = header_mask_q;
		dcfg.high_resolution = high_res_q;
		dcfg.slot_first_a    = slot_first_a_q;
		dcfg.slot_second_a   = slot_second_a_q;
		dcfg.slot_first_b    = slot_first_b_q;
		dcfg.slot_second_b   = slot_second_b_q;
	end

	tdcwd_decode u_decode (
		.word (item_q.word),
		.cfg  (dcfg),
		.dec  (dec)
	);

	// buffer bookkeeping: first_word restarts before the word is judged
	assign first       = item_q.first_word;
	assign stopped_eff = stopped_q && !first;
	assign words_eff   = first ? 16'd0 : words_q;
	assign words_inc   = (words_eff != WORDS_SAT) ? words_eff + 16'd1 : words_eff;

	// table channel of a data word: module * stride + channel
	assign data_idx  = (dec.module_sel ? {1'b0, cpm_q} : 8'd0) + {2'b00, dec.chan};
	assign data_oob  = (data_idx >= 8'(TABLE_CH));
	assign query_oob = ({1'b0, item_q.query_channel} >= 8'(TABLE_CH));
	assign cnt_raddr = (item_q.mode == MODE_READBACK) ?
		item_q.query_channel[TIDX_W-1:0] : data_idx[TIDX_W-1:0];

	// count as left by the last write since clear
	assign cnt_cur  = cnt_vld_rd_q ? cnt_rdata_q : 8'd0;
	assign cnt_next = (cnt_cur != COUNT_SAT) ? cnt_cur + 8'd1 : cnt_cur;
	assign rb_hit   = ({2'b00, item_q.query_hit} < cnt_cur) &&
		({2'b00, item_q.query_hit} < 8'(MAX_HITS));

	assign cnt_we = (state_q == ST_CNT) && (item_q.mode == MODE_READOUT);
	assign tim_we = cnt_we && (cnt_cur < 8'(MAX_HITS));
	assign tim_re = (state_q == ST_CNT) && (item_q.mode == MODE_READBACK) && rb_hit;

	assign tim_base = TADDR_W'(tab_addr_q * MAX_HITS);
	assign tim_addr = tim_base + ((item_q.mode == MODE_READOUT) ?
		TADDR_W'(cnt_cur) : TADDR_W'(item_q.query_hit));

	// hit table RAMs, registered read
	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[tab_addr_q] <= cnt_next;
		end
		if (state_q == ST_DEC) begin
			cnt_rdata_q <= cnt_mem[cnt_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (tim_we) begin
			tim_mem[tim_addr] <= item_q.word[15:0];
		end
		if (tim_re) begin
			tim_rdata_q <= tim_mem[tim_addr];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (item_acc) begin
			item_q <= item_data;
		end
		if (state_q == ST_DEC) begin
			tab_addr_q   <= cnt_raddr;
			cnt_vld_rd_q <= cnt_vld_q[cnt_raddr];
		end
		if (state_q == ST_OUT && out_free) begin
			out_q <= res_q;
		end
		case (state_q)
			ST_DEC: begin
				res_q <= '0;
				if (item_q.mode == MODE_READBACK) begin
					res_q.kind        <= KIND_READBACK;
					res_q.channel     <= item_q.query_channel[5:0];
					res_q.words_seen  <= words_q;
					res_q.hit_dropped <= query_oob;
				end else if (!dec.in_buffer) begin
					res_q.kind       <= KIND_END;
					res_q.words_seen <= words_eff;
				end else begin
					res_q.kind                 <= KIND_DATA;
					res_q.channel              <= dec.chan;
					res_q.value                <= dec.raw;
					res_q.module_index         <= dec.module_sel;
					res_q.slot_number          <= dec.slot;
					res_q.slot_known           <= dec.known;
					res_q.hit_fifo_overflow    <= dec.hfo;
					res_q.output_fifo_overflow <= dec.ofo;
					res_q.lock_failure         <= dec.lockf;
					res_q.hit_dropped          <= dec.store && data_oob;
					res_q.words_seen           <= words_inc;
				end
			end
			ST_CNT: begin
				if (item_q.mode == MODE_READOUT) begin
					res_q.hit_count   <= cnt_next;
					res_q.hit_dropped <= !tim_we;
				end else begin
					res_q.hit_count <= cnt_cur;
				end
			end
			ST_TIM: begin
				res_q.value <= tim_rdata_q;
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			stopped_q   <= 1'b0;
			words_q     <= '0;
			out_valid_q <= 1'b0;
			cnt_vld_q   <= '0;
		end else begin
			if (out_valid_q && !result_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cnt_we) begin
				cnt_vld_q[tab_addr_q] <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (item_acc) begin
						if (item_data.mode == MODE_CLEAR) begin
							cnt_vld_q <= '0;
						end else if (item_data.mode == MODE_READOUT ||
								item_data.mode == MODE_READBACK) begin
							state_q <= ST_DEC;
						end
					end
				end
				ST_DEC: begin
					if (item_q.mode == MODE_READBACK) begin
						state_q <= query_oob ? ST_OUT : ST_CNT;
					end else begin
						stopped_q <= stopped_eff;
						words_q   <= words_eff;
						if (stopped_eff) begin
							state_q <= ST_IDLE;
						end else if (!dec.in_buffer) begin
							stopped_q <= 1'b1;
							state_q   <= ST_OUT;
						end else if (!dec.is_data) begin
							state_q <= ST_IDLE;
						end else begin
							words_q <= words_inc;
							state_q <= (dec.store && !data_oob) ? ST_CNT : ST_OUT;
						end
					end
				end
				ST_CNT: begin
					state_q <= tim_re ? ST_TIM : ST_OUT;
				end
				ST_TIM: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTH
	// time RAM is only ever written inside its depth
	a_tim_waddr: assert property (@(posedge clk) disable iff (!arst_n)
		tim_we |-> (32'(tim_addr) < 32'(TIMES)))
		else $error("time RAM write address out of range");

	// a new result only comes from the output hand-off state
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_OUT))
		else $error("result offered outside hand-off");

	// an end-of-buffer word leaves the buffer stopped
	a_stop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DEC && item_q.mode == MODE_READOUT && !stopped_eff &&
			!dec.in_buffer) |=> stopped_q)
		else $error("end of buffer did not stop the buffer");

	// a clear leaves every count reading as zero
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(item_acc && item_data.mode == MODE_CLEAR) |=> (cnt_vld_q == '0))
		else $error("clear left valid counts");
`endif

endmodule
